// File: rtl/core/glb_pkg.sv
package glb_pkg;

  // Screen and glyph limits.
  localparam int SCREEN_WIDTH     = 800;
  localparam int SCREEN_HEIGHT    = 480;
  localparam int MAX_GLYPH_WIDTH  = 64;
  localparam int MAX_GLYPH_HEIGHT = 64;
  localparam int MAX_GLYPHS       = 64;

  // Field widths of the ports.
  localparam int PIX_BITS = 8;
  localparam int COORD_W  = 11;
  localparam int DIM_W    = 7;
  localparam int COLOR_W  = 32;
  localparam int X_W      = 10;
  localparam int Y_W      = 9;
  localparam int ADDR_W   = 19;
  localparam int BIT_W    = $clog2(PIX_BITS);

  // Derived bounds and counter widths.
  localparam int MAX_BPR = MAX_GLYPH_WIDTH / 8;
  localparam int BPR_W   = $clog2(MAX_BPR + 1);
  localparam int H_W     = $clog2(MAX_GLYPH_HEIGHT + 1);
  localparam int CNT_W   = $clog2(MAX_GLYPHS + 1);
  localparam int BYTE_W  = (MAX_BPR > 1) ? $clog2(MAX_BPR) : 1;
  localparam int ROW_W   = (MAX_GLYPH_HEIGHT > 1) ? $clog2(MAX_GLYPH_HEIGHT) : 1;
  localparam int SLOT_W  = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;

  // Signed working widths for screen coordinates, with headroom for the sign.
  localparam int BX_W = $clog2(MAX_GLYPHS * MAX_GLYPH_WIDTH + 1024 + SCREEN_WIDTH) + 2;
  localparam int PY_W = $clog2(MAX_GLYPH_HEIGHT + 1024 + SCREEN_HEIGHT) + 2;

  localparam int FIFO_DEPTH = 4;

  // Register indexes of the configuration channel.
  typedef enum logic [2:0] {
    REG_ORIGIN_X      = 3'd0,
    REG_ORIGIN_Y      = 3'd1,
    REG_INK_COLOR     = 3'd2,
    REG_GLYPH_WIDTH   = 3'd3,
    REG_GLYPH_HEIGHT  = 3'd4,
    REG_GLYPH_COUNT   = 3'd5,
    REG_REVERSE_ORDER = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic [COORD_W-1:0] origin_x;
    logic [COORD_W-1:0] origin_y;
    logic [COLOR_W-1:0] ink_color;
    logic [DIM_W-1:0]   glyph_width;
    logic [DIM_W-1:0]   glyph_height;
    logic [DIM_W-1:0]   glyph_count;
    logic               reverse_order;
  } cfg_t;

  // One classified font byte: where its leftmost pixel lands and which
  // of its eight pixels are both set and on screen (bit 0 is leftmost).
  typedef struct packed {
    logic [BX_W-1:0]     base_x;
    logic [Y_W-1:0]      y;
    logic [ADDR_W-1:0]   row_base;
    logic [PIX_BITS-1:0] mask;
  } blit_t;

endpackage

// File: rtl/core/glb_front.sv
module glb_front (
  input  logic           clk,
  input  logic           rst,
  input  glb_pkg::cfg_t  cfg,
  input  logic           push,
  input  logic           full,
  input  logic [7:0]     font_byte,
  input  logic           restart,
  output logic           wr_en,
  output glb_pkg::blit_t wr_data
);

  logic [glb_pkg::SLOT_W-1:0] glyph_slot, glyph_slot_next, slot_e;
  logic [glb_pkg::ROW_W-1:0]  row_in_glyph, row_in_glyph_next, row_e;
  logic [glb_pkg::BYTE_W-1:0] byte_in_row, byte_in_row_next, byte_e;

  logic [3:0]                 bpr_raw;
  logic [glb_pkg::BPR_W-1:0]  bpr;
  logic [glb_pkg::H_W-1:0]    h;
  logic [glb_pkg::CNT_W-1:0]  cnt;
  logic [glb_pkg::CNT_W-1:0]  pos;
  logic [glb_pkg::BX_W-1:0]   xoff, bx;
  logic [glb_pkg::PY_W-1:0]   py;
  logic                       y_ok;
  logic                       accept;
  logic [glb_pkg::BX_W-1:0]   px_b [glb_pkg::PIX_BITS];
  logic [glb_pkg::PIX_BITS-1:0] mask;

  assign accept = push && !full;

  always_comb begin
    // Settings clamped to what the counters can use.
    bpr_raw = cfg.glyph_width[glb_pkg::DIM_W-1:3];
    if (bpr_raw == '0) begin
      bpr = glb_pkg::BPR_W'(1);
    end else if (32'(bpr_raw) > glb_pkg::MAX_BPR) begin
      bpr = glb_pkg::BPR_W'(glb_pkg::MAX_BPR);
    end else begin
      bpr = glb_pkg::BPR_W'(bpr_raw);
    end
    if (cfg.glyph_height == '0) begin
      h = glb_pkg::H_W'(1);
    end else if (32'(cfg.glyph_height) > glb_pkg::MAX_GLYPH_HEIGHT) begin
      h = glb_pkg::H_W'(glb_pkg::MAX_GLYPH_HEIGHT);
    end else begin
      h = glb_pkg::H_W'(cfg.glyph_height);
    end
    if (cfg.glyph_count == '0) begin
      cnt = glb_pkg::CNT_W'(1);
    end else if (32'(cfg.glyph_count) > glb_pkg::MAX_GLYPHS) begin
      cnt = glb_pkg::CNT_W'(glb_pkg::MAX_GLYPHS);
    end else begin
      cnt = glb_pkg::CNT_W'(cfg.glyph_count);
    end

    // A counter left beyond a setting that has since shrunk starts again.
    slot_e = (restart || 32'(glyph_slot) >= 32'(cnt)) ? '0 : glyph_slot;
    row_e  = (restart || 32'(row_in_glyph) >= 32'(h)) ? '0 : row_in_glyph;
    byte_e = (restart || 32'(byte_in_row) >= 32'(bpr)) ? '0 : byte_in_row;

    pos = cfg.reverse_order ? (cnt - glb_pkg::CNT_W'(1) - glb_pkg::CNT_W'(slot_e))
                            : glb_pkg::CNT_W'(slot_e);
    xoff = glb_pkg::BX_W'(32'(pos) * 32'(bpr) * 8 + 32'(byte_e) * 8);
    bx = {{(glb_pkg::BX_W - glb_pkg::COORD_W){cfg.origin_x[glb_pkg::COORD_W-1]}},
          cfg.origin_x} + xoff;
    py = {{(glb_pkg::PY_W - glb_pkg::COORD_W){cfg.origin_y[glb_pkg::COORD_W-1]}},
          cfg.origin_y} + glb_pkg::PY_W'(row_e);
    y_ok = !py[glb_pkg::PY_W-1] && (py < glb_pkg::PY_W'(glb_pkg::SCREEN_HEIGHT));

    for (int b = 0; b < glb_pkg::PIX_BITS; b++) begin
      px_b[b] = bx + glb_pkg::BX_W'(b);
      mask[b] = font_byte[glb_pkg::PIX_BITS-1-b] && y_ok && !px_b[b][glb_pkg::BX_W-1] &&
                (px_b[b] < glb_pkg::BX_W'(glb_pkg::SCREEN_WIDTH));
    end

    // Counter advance: byte, then row, then glyph, wrapping at the end.
    glyph_slot_next   = slot_e;
    row_in_glyph_next = row_e;
    byte_in_row_next  = byte_e + 1'b1;
    if (32'(byte_e) + 1 >= 32'(bpr)) begin
      byte_in_row_next  = '0;
      row_in_glyph_next = row_e + 1'b1;
      if (32'(row_e) + 1 >= 32'(h)) begin
        row_in_glyph_next = '0;
        glyph_slot_next   = slot_e + 1'b1;
        if (32'(slot_e) + 1 >= 32'(cnt)) begin
          glyph_slot_next = '0;
        end
      end
    end
  end

  // Bytes with no visible pixel only move the counters.
  assign wr_en            = accept && (mask != '0);
  assign wr_data.base_x   = bx;
  assign wr_data.y        = py[glb_pkg::Y_W-1:0];
  assign wr_data.row_base = glb_pkg::ADDR_W'(32'(py[glb_pkg::PY_W-2:0]) *
                                              32'(glb_pkg::SCREEN_WIDTH));
  assign wr_data.mask     = mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_slot   <= '0;
      row_in_glyph <= '0;
      byte_in_row  <= '0;
    end else if (accept) begin
      glyph_slot   <= glyph_slot_next;
      row_in_glyph <= row_in_glyph_next;
      byte_in_row  <= byte_in_row_next;
    end
  end

endmodule

// File: rtl/core/glb_fifo.sv
module glb_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  glb_pkg::blit_t wr_data,
  input  logic           rd_en,
  output glb_pkg::blit_t rd_data,
  output logic           full,
  output logic           empty
);

  localparam int PTR_W = (glb_pkg::FIFO_DEPTH > 1) ? $clog2(glb_pkg::FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(glb_pkg::FIFO_DEPTH + 1);

  glb_pkg::blit_t    entries [glb_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full    = (count == CNT_W'(glb_pkg::FIFO_DEPTH));
  assign empty   = (count == '0);
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (32'(wr_ptr) == glb_pkg::FIFO_DEPTH - 1) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (32'(rd_ptr) == glb_pkg::FIFO_DEPTH - 1) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/glb_back.sv
module glb_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [glb_pkg::COLOR_W-1:0] ink_color,
  input  logic                        fifo_empty,
  input  glb_pkg::blit_t              fifo_data,
  output logic                        fifo_rd,
  output logic                        empty,
  input  logic                        pop,
  output logic [glb_pkg::X_W-1:0]     pixel_x,
  output logic [glb_pkg::Y_W-1:0]     pixel_y,
  output logic [glb_pkg::ADDR_W-1:0]  pixel_address,
  output logic [glb_pkg::COLOR_W-1:0] pixel_color,
  output logic                        last_of_byte
);

  glb_pkg::blit_t               cur;
  logic                         cur_valid;
  logic                         out_valid;
  logic                         out_free;
  logic                         emit;
  logic                         last;
  logic [glb_pkg::BIT_W-1:0]    idx;
  logic [glb_pkg::PIX_BITS-1:0] mask_rest;
  logic [glb_pkg::BX_W-1:0]     px;

  always_comb begin
    // Leftmost remaining pixel goes first.
    idx = '0;
    for (int b = glb_pkg::PIX_BITS - 1; b >= 0; b--) begin
      if (cur.mask[b]) begin
        idx = glb_pkg::BIT_W'(b);
      end
    end
    mask_rest = cur.mask & ~(glb_pkg::PIX_BITS'(1) << idx);
    last      = (mask_rest == '0);
    out_free  = !out_valid || pop;
    emit      = cur_valid && out_free;
    fifo_rd   = !fifo_empty && (!cur_valid || (emit && last));
    px        = cur.base_x + glb_pkg::BX_W'(idx);
  end

  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (fifo_rd) begin
        cur       <= fifo_data;
        cur_valid <= 1'b1;
      end else if (emit) begin
        cur.mask  <= mask_rest;
        cur_valid <= !last;
      end
      if (emit) begin
        out_valid     <= 1'b1;
        pixel_x       <= px[glb_pkg::X_W-1:0];
        pixel_y       <= cur.y;
        pixel_address <= cur.row_base + glb_pkg::ADDR_W'(px);
        pixel_color   <= ink_color;
        last_of_byte  <= last;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/core/glyph_bitmap_blitter.sv
// Glyph bitmap blitter: turns a stream of 1-bit-per-pixel font bytes into
// framebuffer pixel writes on an 800 by 480 screen.
// Input channel: a font byte and a restart flag are taken as one word at a
// clock edge with push high and full low. Bytes arrive row by row, glyph by
// glyph, bit 7 leftmost; restart clears the glyph, row and byte counters.
// Output channel: while empty is low the oldest pixel write stands on the
// result ports, and pop takes it. Each set bit that lands on screen gives
// one word; last_of_byte marks the final word of a byte.
// Configuration: a separate valid/ready write channel, always ready, that
// writes origin, ink colour, glyph size, glyph count and order. It is to be
// used only while the block is idle.
// Timing: the front end takes a byte every cycle while its four-entry queue
// has room; a byte's pixels pass through the queue, the stepper's current
// byte register and the output register. The back end emits one pixel per
// cycle while the receiver takes them, working through a byte's visible
// pixels, from none up to eight, with the single pixel stepper as the limit.
// Reset clears the counters, the queue and the output register and loads
// the default settings. If the receiver stalls, the output word holds, the
// queue fills and full rises.
module glyph_bitmap_blitter (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [glb_pkg::PIX_BITS-1:0] font_byte,
  input  logic                        restart,
  output logic                        empty,
  input  logic                        pop,
  output logic [glb_pkg::X_W-1:0]     pixel_x,
  output logic [glb_pkg::Y_W-1:0]     pixel_y,
  output logic [glb_pkg::ADDR_W-1:0]  pixel_address,
  output logic [glb_pkg::COLOR_W-1:0] pixel_color,
  output logic                        last_of_byte,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [2:0]                  cfg_index,
  input  logic [31:0]                 cfg_data
);

  glb_pkg::cfg_t  cfg;
  logic           q_wr, q_rd, q_empty;
  glb_pkg::blit_t q_wr_data, q_rd_data;

  // The settings registers accept a write in every cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_x      <= '0;
      cfg.origin_y      <= '0;
      cfg.ink_color     <= '0;
      cfg.glyph_width   <= glb_pkg::DIM_W'(16);
      cfg.glyph_height  <= glb_pkg::DIM_W'(16);
      cfg.glyph_count   <= glb_pkg::DIM_W'(1);
      cfg.reverse_order <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (glb_pkg::reg_index_t'(cfg_index))
        glb_pkg::REG_ORIGIN_X:      cfg.origin_x      <= cfg_data[glb_pkg::COORD_W-1:0];
        glb_pkg::REG_ORIGIN_Y:      cfg.origin_y      <= cfg_data[glb_pkg::COORD_W-1:0];
        glb_pkg::REG_INK_COLOR:     cfg.ink_color     <= cfg_data[glb_pkg::COLOR_W-1:0];
        glb_pkg::REG_GLYPH_WIDTH:   cfg.glyph_width   <= cfg_data[glb_pkg::DIM_W-1:0];
        glb_pkg::REG_GLYPH_HEIGHT:  cfg.glyph_height  <= cfg_data[glb_pkg::DIM_W-1:0];
        glb_pkg::REG_GLYPH_COUNT:   cfg.glyph_count   <= cfg_data[glb_pkg::DIM_W-1:0];
        glb_pkg::REG_REVERSE_ORDER: cfg.reverse_order <= cfg_data[0];
        default: begin
          // Writes to unused indices are dropped.
        end
      endcase
    end
  end

  // Front end: counters and classification of each byte into a pixel mask.
  glb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .push      (push),
    .full      (full),
    .font_byte (font_byte),
    .restart   (restart),
    .wr_en     (q_wr),
    .wr_data   (q_wr_data)
  );

  // Short queue that lets the front end run ahead of the pixel stepper.
  glb_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_wr),
    .wr_data (q_wr_data),
    .rd_en   (q_rd),
    .rd_data (q_rd_data),
    .full    (full),
    .empty   (q_empty)
  );

  // Back end: one pixel write per cycle into the output register when free.
  glb_back u_back (
    .clk           (clk),
    .rst           (rst),
    .ink_color     (cfg.ink_color),
    .fifo_empty    (q_empty),
    .fifo_data     (q_rd_data),
    .fifo_rd       (q_rd),
    .empty         (empty),
    .pop           (pop),
    .pixel_x       (pixel_x),
    .pixel_y       (pixel_y),
    .pixel_address (pixel_address),
    .pixel_color   (pixel_color),
    .last_of_byte  (last_of_byte)
  );

endmodule

// File: tb/glyph_bitmap_blitter_tb.sv
module glyph_bitmap_blitter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // The spare register index is decoded by nobody and must leave every
  // setting untouched.
  localparam logic [2:0] REG_SPARE = 3'd7;

  // One framebuffer write as the block should present it.
  typedef struct packed {
    logic [glb_pkg::X_W-1:0]     x;
    logic [glb_pkg::Y_W-1:0]     y;
    logic [glb_pkg::ADDR_W-1:0]  address;
    logic [glb_pkg::COLOR_W-1:0] color;
    logic                        last;
  } pixel_write_t;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 5;
  // Bytes that show no pixel only step the front end's counters, so a short
  // pause after the last expected word is ample.
  localparam int SETTLE_CYCLES = 24;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int RANDOM_PHASES = 4;
  localparam int PHASE_BYTES   = 90;
  localparam int PRESSURE_BYTES = 40;
  localparam int HOLD_OFF_CYCLES = 400;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         push = 1'b0;
  logic                         full;
  logic [glb_pkg::PIX_BITS-1:0] font_byte = '0;
  logic                         restart = 1'b0;
  logic                         empty;
  logic                         pop = 1'b0;
  logic [glb_pkg::X_W-1:0]      pixel_x;
  logic [glb_pkg::Y_W-1:0]      pixel_y;
  logic [glb_pkg::ADDR_W-1:0]   pixel_address;
  logic [glb_pkg::COLOR_W-1:0]  pixel_color;
  logic                         last_of_byte;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [2:0]                   cfg_index = '0;
  logic [31:0]                  cfg_data = '0;

  glyph_bitmap_blitter DUT (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .font_byte     (font_byte),
    .restart       (restart),
    .empty         (empty),
    .pop           (pop),
    .pixel_x       (pixel_x),
    .pixel_y       (pixel_y),
    .pixel_address (pixel_address),
    .pixel_color   (pixel_color),
    .last_of_byte  (last_of_byte),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // Our own copy of the settings, starting from the reset values.
  logic signed [glb_pkg::COORD_W-1:0] set_origin_x = '0;
  logic signed [glb_pkg::COORD_W-1:0] set_origin_y = '0;
  logic [glb_pkg::COLOR_W-1:0]        set_ink      = '0;
  logic [glb_pkg::DIM_W-1:0]          set_width    = 7'd16;
  logic [glb_pkg::DIM_W-1:0]          set_height   = 7'd16;
  logic [glb_pkg::DIM_W-1:0]          set_count    = 7'd1;
  logic                               set_reverse  = 1'b0;

  // Position of the next font byte within the string.
  int at_slot = 0;
  int at_row  = 0;
  int at_byte = 0;

  pixel_write_t pending_pixels[$];

  int failures        = 0;
  int bytes_sent      = 0;
  int pixels_checked  = 0;
  int register_writes = 0;
  int full_waits      = 0;

  // Calm mode switches off all random idling on both sides.
  bit calm = 1'b0;

  // A long hold-off of the receiver is requested by bumping hold_seq; the
  // receiving process notices the change and counts the stretch itself.
  int hold_seq  = 0;
  int hold_len  = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int stall_left = 0;

  // Works out the pixel writes that one font byte causes and queues them,
  // then steps the byte, row and glyph counters on.
  function automatic void predict_font_byte(input logic [glb_pkg::PIX_BITS-1:0] data,
                                            input logic clear);
    int bytes_per_row;
    int rows;
    int glyphs;
    int slot;
    int base_x;
    int px;
    int py;
    int linear;
    int hits;
    pixel_write_t found[glb_pkg::PIX_BITS];

    // Settings outside their sensible range are clamped before use; a
    // width that is not a multiple of eight drops its remainder.
    bytes_per_row = set_width >> 3;
    if (bytes_per_row < 1) bytes_per_row = 1;
    if (bytes_per_row > glb_pkg::MAX_GLYPH_WIDTH / 8)
      bytes_per_row = glb_pkg::MAX_GLYPH_WIDTH / 8;
    rows = set_height;
    if (rows < 1) rows = 1;
    if (rows > glb_pkg::MAX_GLYPH_HEIGHT) rows = glb_pkg::MAX_GLYPH_HEIGHT;
    glyphs = set_count;
    if (glyphs < 1) glyphs = 1;
    if (glyphs > glb_pkg::MAX_GLYPHS) glyphs = glb_pkg::MAX_GLYPHS;

    if (clear) begin
      at_slot = 0;
      at_row  = 0;
      at_byte = 0;
    end
    // A counter left beyond a setting that has since shrunk starts again.
    if (at_slot >= glyphs) at_slot = 0;
    if (at_row >= rows) at_row = 0;
    if (at_byte >= bytes_per_row) at_byte = 0;

    slot   = set_reverse ? glyphs - 1 - at_slot : at_slot;
    base_x = set_origin_x;
    base_x = base_x + slot * bytes_per_row * 8 + at_byte * 8;
    py     = set_origin_y;
    py     = py + at_row;

    hits = 0;
    for (int b = 0; b < glb_pkg::PIX_BITS; b++) begin
      px = base_x + b;
      if (data[glb_pkg::PIX_BITS-1-b] && px >= 0 && px < glb_pkg::SCREEN_WIDTH &&
          py >= 0 && py < glb_pkg::SCREEN_HEIGHT) begin
        linear = py * glb_pkg::SCREEN_WIDTH + px;
        found[hits].x       = px[glb_pkg::X_W-1:0];
        found[hits].y       = py[glb_pkg::Y_W-1:0];
        found[hits].address = linear[glb_pkg::ADDR_W-1:0];
        found[hits].color   = set_ink;
        found[hits].last    = 1'b0;
        hits++;
      end
    end
    for (int i = 0; i < hits; i++) begin
      found[i].last = (i == hits - 1);
      pending_pixels.push_back(found[i]);
    end

    at_byte++;
    if (at_byte >= bytes_per_row) begin
      at_byte = 0;
      at_row++;
      if (at_row >= rows) begin
        at_row = 0;
        at_slot++;
        if (at_slot >= glyphs) at_slot = 0;
      end
    end
  endfunction

  // Writes one register and mirrors it in our copy of the settings. The
  // task lowers valid and waits for another edge, so that a following write
  // raises valid in a later time step than the one that lowered it.
  task automatic write_register(input logic [2:0] index, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (index)
      glb_pkg::REG_ORIGIN_X:      set_origin_x = value[glb_pkg::COORD_W-1:0];
      glb_pkg::REG_ORIGIN_Y:      set_origin_y = value[glb_pkg::COORD_W-1:0];
      glb_pkg::REG_INK_COLOR:     set_ink      = value[glb_pkg::COLOR_W-1:0];
      glb_pkg::REG_GLYPH_WIDTH:   set_width    = value[glb_pkg::DIM_W-1:0];
      glb_pkg::REG_GLYPH_HEIGHT:  set_height   = value[glb_pkg::DIM_W-1:0];
      glb_pkg::REG_GLYPH_COUNT:   set_count    = value[glb_pkg::DIM_W-1:0];
      glb_pkg::REG_REVERSE_ORDER: set_reverse  = value[0];
      default: ;
    endcase
    register_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Loads a whole set of settings. The bits above each register's width
  // carry random junk, which the block has to ignore.
  task automatic write_settings(input int ox, input int oy, input logic [31:0] ink,
                                input int width, input int height, input int count,
                                input bit reverse);
    logic [31:0] word;
    word = $urandom; word[glb_pkg::COORD_W-1:0] = ox[glb_pkg::COORD_W-1:0];
    write_register(glb_pkg::REG_ORIGIN_X, word);
    word = $urandom; word[glb_pkg::COORD_W-1:0] = oy[glb_pkg::COORD_W-1:0];
    write_register(glb_pkg::REG_ORIGIN_Y, word);
    write_register(glb_pkg::REG_INK_COLOR, ink);
    word = $urandom; word[glb_pkg::DIM_W-1:0] = width[glb_pkg::DIM_W-1:0];
    write_register(glb_pkg::REG_GLYPH_WIDTH, word);
    word = $urandom; word[glb_pkg::DIM_W-1:0] = height[glb_pkg::DIM_W-1:0];
    write_register(glb_pkg::REG_GLYPH_HEIGHT, word);
    word = $urandom; word[glb_pkg::DIM_W-1:0] = count[glb_pkg::DIM_W-1:0];
    write_register(glb_pkg::REG_GLYPH_COUNT, word);
    word = $urandom; word[0] = reverse;
    write_register(glb_pkg::REG_REVERSE_ORDER, word);
    if ($urandom_range(0, 2) == 0) write_register(REG_SPARE, $urandom);
  endtask

  // Offers one font byte, with a random gap in front of it unless the run
  // is calm, and waits until the block takes it. Push is left high so that
  // back-to-back bytes need no second assignment in the same time step.
  task automatic send_font_byte(input logic [glb_pkg::PIX_BITS-1:0] data,
                                input logic clear);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 15);
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push      <= 1'b1;
    font_byte <= data;
    restart   <= clear;
    do begin
      @(posedge clk);
      if (full) full_waits++;
    end while (full);
    predict_font_byte(data, clear);
    bytes_sent++;
  endtask

  // Brings the block to rest: no byte offered, every expected word taken,
  // and a short pause for bytes still in flight that show no pixel.
  task automatic settle_block();
    push <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    failures++;
  endtask

  // Receiving side: checks every word taken against the oldest expected
  // one, then decides whether to take a word at the next edge. Outputs are
  // sampled at the edge, before the block updates them.
  always @(posedge clk) begin
    pixel_write_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (pending_pixels.size() == 0) begin
          $display("%0t: unexpected pixel word, actual x %0d y %0d address %0h",
                   $time, pixel_x, pixel_y, pixel_address);
          failures++;
        end else begin
          want = pending_pixels.pop_front();
          pixels_checked++;
          if (pixel_x !== want.x) report_mismatch("pixel_x", want.x, pixel_x);
          if (pixel_y !== want.y) report_mismatch("pixel_y", want.y, pixel_y);
          if (pixel_address !== want.address)
            report_mismatch("pixel_address", want.address, pixel_address);
          if (pixel_color !== want.color)
            report_mismatch("pixel_color", want.color, pixel_color);
          if (last_of_byte !== want.last)
            report_mismatch("last_of_byte", want.last, last_of_byte);
        end
      end
      if (hold_seen != hold_seq) begin
        hold_seen = hold_seq;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        hold_left--;
      end else if (stall_left > 0) begin
        stall_left--;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 15);
      end
      pop <= (hold_left == 0 && stall_left == 0);
    end
  end

  // Bytes under the reset settings: a 16 pixel wide glyph at the corner,
  // so two bytes per row, drawn in ink zero.
  task automatic test_default_settings();
    send_font_byte(8'hFF, 1'b0);
    send_font_byte(8'h00, 1'b0);
    send_font_byte(8'h81, 1'b0);
    settle_block();
  endtask

  // Glyphs that straddle the screen edges, lie wholly off screen at the
  // extreme origins, or partly above the top and left.
  task automatic test_screen_edges();
    write_settings(796, 479, 32'hFFFF_FFFF, 8, 2, 1, 1'b0);
    send_font_byte(8'hFF, 1'b1);  // right edge clips half the byte
    send_font_byte(8'hFF, 1'b0);  // second row lies below the bottom
    settle_block();
    write_settings(-1024, 100, 32'h1234_5678, 8, 1, 1, 1'b0);
    send_font_byte(8'hFF, 1'b1);
    settle_block();
    write_settings(1023, 100, 32'h0000_0001, 8, 1, 1, 1'b0);
    send_font_byte(8'hFF, 1'b1);
    settle_block();
    write_settings(-3, -1, 32'h8000_0000, 8, 2, 1, 1'b0);
    send_font_byte(8'hFF, 1'b1);  // row above the top
    send_font_byte(8'hFF, 1'b0);  // left three pixels off screen
    settle_block();
  endtask

  // Sizes below and above the allowed range, which must be clamped.
  task automatic test_size_limits();
    write_settings(10, 10, 32'hA5A5_5A5A, 5, 0, 0, 1'b0);
    send_font_byte(8'h80, 1'b1);
    send_font_byte(8'h80, 1'b0);
    settle_block();
    write_settings(0, 0, 32'h5A5A_A5A5, 127, 127, 127, 1'b1);
    send_font_byte(8'h01, 1'b1);
    send_font_byte(8'h01, 1'b0);
    settle_block();
  endtask

  // Reverse order places the first glyph rightmost; the fourth byte also
  // shows the counters wrapping at the end of the string.
  task automatic test_reverse_order();
    write_settings(100, 50, 32'hFF00_FF00, 8, 1, 3, 1'b1);
    send_font_byte(8'hC0, 1'b1);
    send_font_byte(8'hC0, 1'b0);
    send_font_byte(8'hC0, 1'b0);
    send_font_byte(8'hC0, 1'b0);
    settle_block();
  endtask

  // Restart in the middle of a string sends the next byte back to glyph 0.
  task automatic test_restart();
    write_settings(200, 60, 32'h00FF_00FF, 8, 1, 3, 1'b0);
    send_font_byte(8'h80, 1'b1);
    send_font_byte(8'h80, 1'b0);
    send_font_byte(8'h80, 1'b1);
    settle_block();
  endtask

  // Counters left beyond a setting that shrinks in between are reused as
  // zero: first the byte counter, then the row, then the glyph.
  task automatic test_shrunk_settings();
    write_settings(300, 70, 32'hC0FF_EE00, 16, 2, 2, 1'b0);
    send_font_byte(8'hF0, 1'b1);
    settle_block();
    write_register(glb_pkg::REG_GLYPH_WIDTH, 32'd8);
    send_font_byte(8'h0F, 1'b0);
    settle_block();
    write_register(glb_pkg::REG_GLYPH_HEIGHT, 32'd1);
    send_font_byte(8'h3C, 1'b0);
    settle_block();
    write_register(glb_pkg::REG_GLYPH_COUNT, 32'd1);
    send_font_byte(8'hC3, 1'b0);
    settle_block();
  endtask

  // The receiver holds off for a long stretch while bytes with visible
  // pixels keep coming, so the queue fills and the input has to stall.
  task automatic test_full_queue();
    write_settings(0, 0, $urandom, 64, 8, 1, 1'b0);
    hold_len = HOLD_OFF_CYCLES;
    hold_seq++;
    send_font_byte(8'hFF, 1'b1);
    for (int i = 1; i < PRESSURE_BYTES; i++)
      send_font_byte(8'h80 | glb_pkg::PIX_BITS'($urandom), 1'b0);
    settle_block();
  endtask

  // Random strings: mostly small glyphs placed near or on the screen, now
  // and then a setting drawn from the whole range of its register.
  task automatic test_random_strings(input int items);
    int ox;
    int oy;
    int width;
    int height;
    int count;
    logic [glb_pkg::PIX_BITS-1:0] data;
    ox = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 840) - 40 : $urandom;
    oy = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 490) - 8 : $urandom;
    width  = ($urandom_range(0, 3) != 0) ? 8 * $urandom_range(1, 2) : $urandom;
    height = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 8) : $urandom;
    count  = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 4) : $urandom;
    write_settings(ox, oy, $urandom, width, height, count, $urandom_range(0, 1));
    for (int i = 0; i < items; i++) begin
      case ($urandom_range(0, 7))
        0:       data = 8'h00;
        1:       data = 8'hFF;
        default: data = $urandom;
      endcase
      send_font_byte(data, (i == 0) || ($urandom_range(0, 23) == 0));
    end
    settle_block();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_default_settings();
    test_screen_edges();
    test_size_limits();
    test_reverse_order();
    test_restart();
    test_shrunk_settings();
    test_full_queue();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      // The final phase runs flat out on both sides.
      calm = (p == RANDOM_PHASES - 1);
      test_random_strings(PHASE_BYTES);
    end

    // Final wait, bounded: anything still expected after it has been lost.
    push <= 1'b0;
    for (int i = 0; i < DRAIN_LIMIT && pending_pixels.size() != 0; i++)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_pixels.size() != 0) begin
      $display("%0t: %0d expected pixel words never arrived", $time,
               pending_pixels.size());
      failures += pending_pixels.size();
    end

    $display("Drew %0d font bytes into %0d checked pixel words under %0d register writes,",
             bytes_sent, pixels_checked, register_writes);
    $display("with the input held back by a full queue on %0d cycles.", full_waits);
    if (failures == 0) begin
      $display("glyph_bitmap_blitter_tb OK");
    end else begin
      $display("glyph_bitmap_blitter_tb NOT OK");
    end
    $finish;
  end

  // Safety net: a hung handshake ends the run as a failure.
  initial begin
    #3_000_000;
    $display("%0t: timeout", $time);
    $display("glyph_bitmap_blitter_tb NOT OK");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/glb_pkg.sv
rtl/core/glb_front.sv
rtl/core/glb_fifo.sv
rtl/core/glb_back.sv
rtl/core/glyph_bitmap_blitter.sv
tb/glyph_bitmap_blitter_tb.sv
